>>> hw/rtl/fte_pkg.sv
// Package for the FAT12 table engine: beat and payload types, request codes,
// the control word of the sequencer, status flags and fixed constants.
// No dependencies; every other file of the engine imports it.
`timescale 1ns / 1ps

package fte_pkg;

	typedef logic [2:0]  req_type_t;
	typedef logic [11:0] entry_t;
	typedef logic [12:0] byte_addr_t;
	typedef logic [7:0]  byte_t;
	typedef logic [12:0] count_t;
	typedef logic [4:0]  upc_t;

	localparam req_type_t REQ_RD_ENTRY  = 3'd0;
	localparam req_type_t REQ_WR_ENTRY  = 3'd1;
	localparam req_type_t REQ_RD_BYTE   = 3'd2;
	localparam req_type_t REQ_WR_BYTE   = 3'd3;
	localparam req_type_t REQ_FIND_FREE = 3'd4;
	localparam req_type_t REQ_CNT_FREE  = 3'd5;
	localparam req_type_t REQ_CLR_CHAIN = 3'd6;
	localparam req_type_t REQ_CNT_CHAIN = 3'd7;

	localparam entry_t END_MARK      = 12'hFF7;
	localparam count_t MAX_ENTRY_RST = 13'd4096;

	// Division of a byte address by three: (addr * 43691) >> 17 is exact
	// for every 13-bit address.
	localparam logic [15:0] RECIP3       = 16'd43691;
	localparam int          RECIP3_SHIFT = 17;

	// One row of the store holds an entry pair: three bytes, six nibbles.
	localparam int ROW_BITS = 24;
	localparam int NIBBLES  = 6;

	typedef struct packed {
		req_type_t  req_type;
		entry_t     cluster_index;
		entry_t     entry_value;
		byte_addr_t byte_address;
		byte_t      byte_data;
	} req_beat_t;

	typedef enum logic [1:0] {RD_NONE, RD_CUR, RD_BYTE, RD_SCAN} rd_sel_t;
	typedef enum logic [1:0] {WR_NONE, WR_ENTRY, WR_ZERO, WR_BYTE} wr_sel_t;
	typedef enum logic [1:0] {CNT_HOLD, CNT_LOAD0, CNT_LOAD2, CNT_INC} cnt_op_t;
	typedef enum logic [1:0] {ACC_HOLD, ACC_CLEAR, ACC_INC_FREE} acc_op_t;
	typedef enum logic [1:0] {BR_NEVER, BR_SCAN_END, BR_FREE, BR_CHAIN_END} br_cond_t;
	typedef enum logic [2:0] {
		OUT_ZERO, OUT_ENTRY, OUT_BYTE, OUT_CNT_PREV, OUT_ACC, OUT_STEPS
	} out_sel_t;

	typedef struct packed {
		rd_sel_t  rd_sel;
		wr_sel_t  wr_sel;
		cnt_op_t  cnt_op;
		acc_op_t  acc_op;
		logic     cur_ld;
		br_cond_t br_cond;
		logic     emit;
		out_sel_t out_sel;
		upc_t     nxt;
		upc_t     tgt;
	} ctrl_word_t;

	typedef struct packed {
		logic clearing;
		logic stall;
		logic scan_end;
		logic free;
		logic chain_end;
	} dp_status_t;

endpackage

>>> hw/rtl/fte_req_if.sv
// Request channel of the FAT12 table engine: valid, ready and one request.
// Depends on fte_pkg for the payload types.
`timescale 1ns / 1ps

interface fte_req_if import fte_pkg::*; ();
	logic       valid;
	logic       ready;
	req_type_t  req_type;
	entry_t     cluster_index;
	entry_t     entry_value;
	byte_addr_t byte_address;
	byte_t      byte_data;

	modport source (
		output valid, req_type, cluster_index, entry_value, byte_address, byte_data,
		input  ready
	);
	modport sink (
		input  valid, req_type, cluster_index, entry_value, byte_address, byte_data,
		output ready
	);
endinterface

>>> hw/rtl/fte_rsp_if.sv
// Result channel of the FAT12 table engine: valid, ready and one result.
// Depends on fte_pkg for the payload types.
`timescale 1ns / 1ps

interface fte_rsp_if import fte_pkg::*; ();
	logic   valid;
	logic   ready;
	count_t result_value;
	logic   chain_overrun;

	modport source (output valid, result_value, chain_overrun, input ready);
	modport sink (input valid, result_value, chain_overrun, output ready);
endinterface

>>> hw/rtl/fte_table_ram.sv
// Table store: one row per entry pair, nibble write mask, registered read.
// Depends on fte_pkg for the row geometry.
`timescale 1ns / 1ps

module fte_table_ram import fte_pkg::*; #(
	parameter int ROWS = 2048,
	localparam int ROW_W = $clog2(ROWS)
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [ROW_W-1:0]    wr_row,
	input  logic [NIBBLES-1:0]  wr_mask,
	input  logic [ROW_BITS-1:0] wr_data,
	input  logic                rd_en,
	input  logic [ROW_W-1:0]    rd_row,
	output logic [ROW_BITS-1:0] rd_data
);

	logic [ROW_BITS-1:0] mem_q [ROWS];
	logic [ROW_BITS-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int k = 0; k < NIBBLES; k++) begin
				if (wr_mask[k]) begin
					mem_q[wr_row][4*k +: 4] <= wr_data[4*k +: 4];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_row];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> hw/rtl/fte_datapath.sv
// Datapath of the FAT12 table engine: request registers, scan and step
// counters, the table store with its clearing pass, and the result register.
// Depends on fte_pkg and fte_table_ram; steered by control words from fte_sequencer.
`timescale 1ns / 1ps

module fte_datapath import fte_pkg::*; #(
	parameter int ENTRY_COUNT = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	input  count_t     max_entry,
	input  logic       in_fire,
	input  req_beat_t  req_beat,
	input  ctrl_word_t ctrl,
	output dp_status_t st,
	input  logic       rsp_ready,
	output logic       rsp_valid,
	output count_t     rsp_value,
	output logic       rsp_over
);

	localparam int ROWS = (ENTRY_COUNT + 1) / 2;
	localparam int ROW_W = $clog2(ROWS);
	localparam int TABLE_SIZE = (ENTRY_COUNT * 3 + 1) / 2;
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
	localparam count_t ENTRY_LIM = 13'(ENTRY_COUNT);
	localparam logic [13:0] BYTE_LIM = 14'(TABLE_SIZE);

	entry_t              cur_q;
	entry_t              val_q;
	byte_addr_t          addr_q;
	byte_t               data_q;
	logic [28:0]         prod_q;
	count_t              cnt_q;
	count_t              acc_q;
	logic                over_q;
	logic                rd_par_q;
	logic                rd_ok_q;
	logic                clearing_q;
	logic [ROW_W-1:0]    clr_row_q;
	logic                rsp_valid_q;
	count_t              rsp_value_q;
	logic                rsp_over_q;

	logic                step_en;
	logic                stall;
	logic                cur_ok;
	logic                byte_ok;
	logic [11:0]         byte_row;
	logic [12:0]         three_row;
	logic [12:0]         lane_diff;
	logic [1:0]          lane;
	count_t              lim;
	count_t              lim_c;
	logic [ROW_BITS-1:0] rd_data;
	entry_t              entry_rd;
	byte_t               byte_sel;
	byte_t               byte_rd;
	count_t              out_value;
	logic                out_load;

	logic                ram_wr_en;
	logic [ROW_W-1:0]    ram_wr_row;
	logic [NIBBLES-1:0]  ram_wr_mask;
	logic [ROW_BITS-1:0] ram_wr_data;
	logic                ram_rd_en;
	logic [ROW_W-1:0]    ram_rd_row;

	// Byte address split into row and byte lane within the row.
	assign byte_row  = prod_q[RECIP3_SHIFT +: 12];
	assign three_row = {byte_row, 1'b0} + {1'b0, byte_row};
	assign lane_diff = addr_q - three_row;
	assign lane      = lane_diff[1:0];
	assign byte_ok   = {1'b0, addr_q} < BYTE_LIM;
	assign cur_ok    = {1'b0, cur_q} < ENTRY_LIM;

	assign lim   = (max_entry < ENTRY_LIM) ? max_entry : ENTRY_LIM;
	assign lim_c = (lim == '0) ? 13'd1 : lim;

	assign entry_rd = rd_ok_q ? (rd_par_q ? rd_data[23:12] : rd_data[11:0]) : '0;

	always_comb begin
		unique case (lane)
			2'd0:    byte_sel = rd_data[7:0];
			2'd1:    byte_sel = rd_data[15:8];
			2'd2:    byte_sel = rd_data[23:16];
			default: byte_sel = '0;
		endcase
	end
	assign byte_rd = byte_ok ? byte_sel : '0;

	assign stall    = ctrl.emit && rsp_valid_q && !rsp_ready;
	assign step_en  = !stall;
	assign out_load = ctrl.emit && step_en;

	assign st.clearing  = clearing_q;
	assign st.stall     = stall;
	assign st.scan_end  = cnt_q >= lim;
	assign st.free      = entry_rd == '0;
	assign st.chain_end = (entry_rd >= END_MARK) || (({1'b0, cnt_q} + 14'd1) >= {1'b0, lim_c});

	always_comb begin
		unique case (ctrl.out_sel)
			OUT_ZERO:     out_value = '0;
			OUT_ENTRY:    out_value = {1'b0, entry_rd};
			OUT_BYTE:     out_value = {5'b0, byte_rd};
			OUT_CNT_PREV: out_value = cnt_q - 13'd1;
			OUT_ACC:      out_value = acc_q;
			OUT_STEPS:    out_value = cnt_q;
			default:      out_value = '0;
		endcase
	end

	// Store port steering; the clearing pass owns the write port after reset.
	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_row  = ROW_W'(cur_q[11:1]);
		ram_wr_mask = cur_q[0] ? 6'b111000 : 6'b000111;
		ram_wr_data = {val_q, val_q};
		if (clearing_q) begin
			ram_wr_en   = 1'b1;
			ram_wr_row  = clr_row_q;
			ram_wr_mask = '1;
			ram_wr_data = '0;
		end else begin
			unique case (ctrl.wr_sel)
				WR_NONE: ram_wr_en = 1'b0;
				WR_ENTRY: ram_wr_en = step_en && cur_ok;
				WR_ZERO: begin
					ram_wr_en   = step_en && cur_ok;
					ram_wr_data = '0;
				end
				WR_BYTE: begin
					ram_wr_en  = step_en && byte_ok;
					ram_wr_row = ROW_W'(byte_row);
					ram_wr_data = {data_q, data_q, data_q};
					unique case (lane)
						2'd0:    ram_wr_mask = 6'b000011;
						2'd1:    ram_wr_mask = 6'b001100;
						2'd2:    ram_wr_mask = 6'b110000;
						default: ram_wr_mask = 6'b000000;
					endcase
				end
				default: ram_wr_en = 1'b0;
			endcase
		end
	end

	always_comb begin
		ram_rd_en = step_en && (ctrl.rd_sel != RD_NONE);
		unique case (ctrl.rd_sel)
			RD_CUR:  ram_rd_row = ROW_W'(cur_q[11:1]);
			RD_BYTE: ram_rd_row = ROW_W'(byte_row);
			RD_SCAN: ram_rd_row = ROW_W'(cnt_q[11:1]);
			default: ram_rd_row = ROW_W'(cur_q[11:1]);
		endcase
	end

	fte_table_ram #(
		.ROWS(ROWS)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_row  (ram_wr_row),
		.wr_mask (ram_wr_mask),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_row  (ram_rd_row),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cur_q  <= req_beat.cluster_index;
			val_q  <= req_beat.entry_value;
			addr_q <= req_beat.byte_address;
			data_q <= req_beat.byte_data;
			prod_q <= {16'b0, req_beat.byte_address} * {13'b0, RECIP3};
		end else if (step_en && ctrl.cur_ld) begin
			cur_q <= entry_rd;
		end
		if (step_en) begin
			if (ctrl.cur_ld) begin
				over_q <= entry_rd < END_MARK;
			end
			unique case (ctrl.cnt_op)
				CNT_HOLD:  cnt_q <= cnt_q;
				CNT_LOAD0: cnt_q <= 13'd0;
				CNT_LOAD2: cnt_q <= 13'd2;
				CNT_INC:   cnt_q <= cnt_q + 13'd1;
				default:   cnt_q <= cnt_q;
			endcase
			unique case (ctrl.acc_op)
				ACC_HOLD:     acc_q <= acc_q;
				ACC_CLEAR:    acc_q <= 13'd0;
				ACC_INC_FREE: acc_q <= st.free ? acc_q + 13'd1 : acc_q;
				default:      acc_q <= acc_q;
			endcase
			// Remember which half of the row, and whether it exists at all.
			if (ctrl.rd_sel == RD_CUR) begin
				rd_par_q <= cur_q[0];
				rd_ok_q  <= cur_ok;
			end else if (ctrl.rd_sel == RD_SCAN) begin
				rd_par_q <= cnt_q[0];
				rd_ok_q  <= 1'b1;
			end
		end
		if (out_load) begin
			rsp_value_q <= out_value;
			rsp_over_q  <= (ctrl.out_sel == OUT_STEPS) && over_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q  <= 1'b1;
			clr_row_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_row_q <= clr_row_q + 1'b1;
				if (clr_row_q == LAST_ROW) begin
					clearing_q <= 1'b0;
				end
			end
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_value = rsp_value_q;
	assign rsp_over  = rsp_over_q;

	a_no_accept_while_clearing: assert property (
		@(posedge clk) disable iff (!arst_n) clearing_q |-> !in_fire
	) else $error("request accepted during the clearing pass");

	a_no_step_write_while_clearing: assert property (
		@(posedge clk) disable iff (!arst_n) clearing_q |-> ctrl.wr_sel == WR_NONE
	) else $error("sequencer write issued during the clearing pass");

	a_no_write_on_stall: assert property (
		@(posedge clk) disable iff (!arst_n) stall |-> !ram_wr_en
	) else $error("table written while the result beat is stalled");

	a_free_hit_above_one: assert property (
		@(posedge clk) disable iff (!arst_n)
		out_load && ctrl.out_sel == OUT_CNT_PREV |-> cnt_q >= 13'd3
	) else $error("free cluster result below two");

endmodule

>>> hw/rtl/fte_sequencer.sv
// Microcode sequencer of the FAT12 table engine: step counter, control ROM,
// request dispatch and conditional jumps on datapath status.
// Depends on fte_pkg for the control word and status types.
`timescale 1ns / 1ps

module fte_sequencer import fte_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  req_type_t  req_type,
	input  dp_status_t st,
	output logic       req_ready,
	output ctrl_word_t ctrl
);

	localparam upc_t PC_IDLE  = 5'd0;
	localparam upc_t PC_RE0   = 5'd1;
	localparam upc_t PC_RE1   = 5'd2;
	localparam upc_t PC_WE0   = 5'd3;
	localparam upc_t PC_RB0   = 5'd4;
	localparam upc_t PC_RB1   = 5'd5;
	localparam upc_t PC_WB0   = 5'd6;
	localparam upc_t PC_F0    = 5'd7;
	localparam upc_t PC_F1    = 5'd8;
	localparam upc_t PC_F2    = 5'd9;
	localparam upc_t PC_FHIT  = 5'd10;
	localparam upc_t PC_FNONE = 5'd11;
	localparam upc_t PC_C0    = 5'd12;
	localparam upc_t PC_C1    = 5'd13;
	localparam upc_t PC_C2    = 5'd14;
	localparam upc_t PC_CEND  = 5'd15;
	localparam upc_t PC_K0    = 5'd16;
	localparam upc_t PC_K1    = 5'd17;
	localparam upc_t PC_K2    = 5'd18;
	localparam upc_t PC_Z0    = 5'd19;
	localparam upc_t PC_Z1    = 5'd20;
	localparam upc_t PC_Z2    = 5'd21;
	localparam upc_t PC_KEND  = 5'd22;

	localparam ctrl_word_t CW_IDLE = '{
		rd_sel: RD_NONE, wr_sel: WR_NONE, cnt_op: CNT_HOLD, acc_op: ACC_HOLD,
		cur_ld: 1'b0, br_cond: BR_NEVER, emit: 1'b0, out_sel: OUT_ZERO,
		nxt: PC_IDLE, tgt: PC_IDLE
	};

	function automatic ctrl_word_t ucode(input upc_t pc);
		ctrl_word_t w;
		w = CW_IDLE;
		unique case (pc)
			PC_RE0: begin w.rd_sel = RD_CUR; w.nxt = PC_RE1; end
			PC_RE1: begin w.emit = 1'b1; w.out_sel = OUT_ENTRY; end
			PC_WE0: begin w.wr_sel = WR_ENTRY; w.emit = 1'b1; end
			PC_RB0: begin w.rd_sel = RD_BYTE; w.nxt = PC_RB1; end
			PC_RB1: begin w.emit = 1'b1; w.out_sel = OUT_BYTE; end
			PC_WB0: begin w.wr_sel = WR_BYTE; w.emit = 1'b1; end
			PC_F0: begin w.cnt_op = CNT_LOAD2; w.nxt = PC_F1; end
			PC_F1: begin
				w.rd_sel = RD_SCAN; w.br_cond = BR_SCAN_END;
				w.tgt = PC_FNONE; w.nxt = PC_F2;
			end
			PC_F2: begin
				w.cnt_op = CNT_INC; w.br_cond = BR_FREE;
				w.tgt = PC_FHIT; w.nxt = PC_F1;
			end
			PC_FHIT: begin w.emit = 1'b1; w.out_sel = OUT_CNT_PREV; end
			PC_FNONE: w.emit = 1'b1;
			PC_C0: begin w.cnt_op = CNT_LOAD2; w.acc_op = ACC_CLEAR; w.nxt = PC_C1; end
			PC_C1: begin
				w.rd_sel = RD_SCAN; w.br_cond = BR_SCAN_END;
				w.tgt = PC_CEND; w.nxt = PC_C2;
			end
			PC_C2: begin w.acc_op = ACC_INC_FREE; w.cnt_op = CNT_INC; w.nxt = PC_C1; end
			PC_CEND: begin w.emit = 1'b1; w.out_sel = OUT_ACC; end
			PC_K0: begin w.cnt_op = CNT_LOAD0; w.nxt = PC_K1; end
			PC_K1: begin w.rd_sel = RD_CUR; w.nxt = PC_K2; end
			PC_K2: begin
				w.cnt_op = CNT_INC; w.cur_ld = 1'b1; w.br_cond = BR_CHAIN_END;
				w.tgt = PC_KEND; w.nxt = PC_K1;
			end
			PC_Z0: begin w.cnt_op = CNT_LOAD0; w.nxt = PC_Z1; end
			PC_Z1: begin w.rd_sel = RD_CUR; w.nxt = PC_Z2; end
			PC_Z2: begin
				w.wr_sel = WR_ZERO; w.cnt_op = CNT_INC; w.cur_ld = 1'b1;
				w.br_cond = BR_CHAIN_END; w.tgt = PC_KEND; w.nxt = PC_Z1;
			end
			PC_KEND: begin w.emit = 1'b1; w.out_sel = OUT_STEPS; end
			default: w = CW_IDLE;
		endcase
		return w;
	endfunction

	function automatic upc_t entry_pc(input req_type_t rt);
		upc_t pc;
		pc = PC_IDLE;
		unique case (rt)
			REQ_RD_ENTRY:  pc = PC_RE0;
			REQ_WR_ENTRY:  pc = PC_WE0;
			REQ_RD_BYTE:   pc = PC_RB0;
			REQ_WR_BYTE:   pc = PC_WB0;
			REQ_FIND_FREE: pc = PC_F0;
			REQ_CNT_FREE:  pc = PC_C0;
			REQ_CLR_CHAIN: pc = PC_Z0;
			REQ_CNT_CHAIN: pc = PC_K0;
			default:       pc = PC_IDLE;
		endcase
		return pc;
	endfunction

	upc_t pc_q;
	logic taken;
	logic in_fire;

	assign ctrl      = ucode(pc_q);
	assign req_ready = (pc_q == PC_IDLE) && !st.clearing;
	assign in_fire   = req_valid && req_ready;

	always_comb begin
		unique case (ctrl.br_cond)
			BR_NEVER:     taken = 1'b0;
			BR_SCAN_END:  taken = st.scan_end;
			BR_FREE:      taken = st.free;
			BR_CHAIN_END: taken = st.chain_end;
			default:      taken = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			priority if (in_fire) begin
				pc_q <= entry_pc(req_type);
			end else if (st.stall) begin
				pc_q <= pc_q;
			end else begin
				pc_q <= taken ? ctrl.tgt : ctrl.nxt;
			end
		end
	end

endmodule

>>> hw/rtl/fat12_table_engine.sv
// Top level of the FAT12 allocation table engine: configuration register,
// channel wiring, microcode sequencer and datapath.
// Depends on fte_pkg, fte_req_if, fte_rsp_if, fte_sequencer and fte_datapath.
//
//   Channel  Role     Beat contents
//   req      sink     req_type, cluster_index, entry_value, byte_address, byte_data
//   rsp      source   result_value, chain_overrun
//   cfg      write    cfg_wr_en, cfg_wr_data (max_entry)
//
// Entry and byte reads issue the row read, then load the result; writes load it with the write.
// Find free, count free and the chain walks use a read step and a test step per entry or link;
// one control word per cycle while the result beat is not stalled, one row read per entry
// through the single registered read port of the store.
// After reset a clearing pass zeroes all (ENTRY_COUNT+1)/2 rows of the store
// (2048 by default) with req.ready low; configuration writes are taken throughout.
// The result register holds a stalled beat while the next request is accepted.
`timescale 1ns / 1ps

module fat12_table_engine import fte_pkg::*; #(
	parameter int ENTRY_COUNT = 4096
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  count_t       cfg_wr_data,
	fte_req_if.sink      req,
	fte_rsp_if.source    rsp
);

	count_t     max_entry_q;
	req_beat_t  req_beat;
	ctrl_word_t ctrl;
	dp_status_t st;
	logic       req_ready;
	logic       in_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entry_q <= MAX_ENTRY_RST;
		end else if (cfg_wr_en) begin
			max_entry_q <= cfg_wr_data;
		end
	end

	assign req_beat.req_type      = req.req_type;
	assign req_beat.cluster_index = req.cluster_index;
	assign req_beat.entry_value   = req.entry_value;
	assign req_beat.byte_address  = req.byte_address;
	assign req_beat.byte_data     = req.byte_data;

	assign req.ready = req_ready;
	assign in_fire   = req.valid && req_ready;

	fte_sequencer u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.st        (st),
		.req_ready (req_ready),
		.ctrl      (ctrl)
	);

	fte_datapath #(
		.ENTRY_COUNT(ENTRY_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.max_entry (max_entry_q),
		.in_fire   (in_fire),
		.req_beat  (req_beat),
		.ctrl      (ctrl),
		.st        (st),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.rsp_value (rsp.result_value),
		.rsp_over  (rsp.chain_overrun)
	);

endmodule
